/* rtl/assert_macros.svh */
// Assertion macros shared by the elevator controller RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that cond never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/esc_pkg.sv */
// Shared types and constants of the elevator scan controller.
// No dependencies; imported by every module of the block.
package esc_pkg;

    localparam int DEF_NUM_FLOORS = 10;
    localparam int DEF_QUEUE_DEPTH = 2;
    localparam int TF_W = 4;     // target_floor field width
    localparam int FLOOR_OUT_W = 4;

    typedef enum logic [1:0] {
        ACT_UP_CALL   = 2'd0,
        ACT_DOWN_CALL = 2'd1,
        ACT_CABIN     = 2'd2,
        ACT_STEP      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        HEAD_IDLE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_heading;

    // Classified command word passed from front to back.
    typedef struct packed {
        t_action          action;
        logic             rejected;
        logic [TF_W-1:0]  floor;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/esc_front.sv */
// Front end: decodes an incoming word and checks the request floor.
// Depends on esc_pkg.
module esc_front #(
    parameter int NUM_FLOORS = esc_pkg::DEF_NUM_FLOORS
) (
    input  logic [1:0]              i_action,
    input  logic [esc_pkg::TF_W-1:0] i_target_floor,
    output esc_pkg::t_cmd           o_cmd
);
    import esc_pkg::*;

    int tf;

    always_comb begin
        tf = int'(i_target_floor);
        o_cmd.action = t_action'(i_action);
        o_cmd.floor = i_target_floor;
        case (t_action'(i_action))
            ACT_UP_CALL:   o_cmd.rejected = !(tf < NUM_FLOORS - 1);
            ACT_DOWN_CALL: o_cmd.rejected = !(tf > 0 && tf < NUM_FLOORS);
            ACT_CABIN:     o_cmd.rejected = !(tf < NUM_FLOORS);
            default:       o_cmd.rejected = 1'b0;
        endcase
    end

endmodule

/* rtl/esc_queue.sv */
// Short command queue between front and back ends.
// Depends on esc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esc_queue #(
    parameter int DEPTH = esc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esc_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output esc_pkg::t_cmd   o_cmd,
    output esc_pkg::t_q_stat o_stat
);
    import esc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop) r_rd <= bump(r_rd);
            if (i_push && !i_pop) r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    assign o_cmd = r_mem[r_rd];
    assign o_stat.full = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_stat.full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_stat.empty, "pop from empty queue")

endmodule

/* rtl/esc_back.sv */
// Back end: car state, SCAN stepping and the registered result word.
// Depends on esc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esc_back #(
    parameter int NUM_FLOORS = esc_pkg::DEF_NUM_FLOORS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  esc_pkg::t_cmd                  i_cmd,
    input  esc_pkg::t_q_stat               i_qstat,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [esc_pkg::FLOOR_OUT_W-1:0] o_floor_now,
    output logic [1:0]                     o_heading,
    output logic                           o_moved,
    output logic                           o_doors_opened,
    output logic                           o_rejected,
    output logic                           o_pending
);
    import esc_pkg::*;

    localparam int FW = $clog2(NUM_FLOORS);

    logic [NUM_FLOORS-1:0] r_up, r_down, r_cab;
    logic [NUM_FLOORS-1:0] n_up, n_down, n_cab;
    logic [FW-1:0] r_floor, n_floor;
    t_heading r_heading, n_heading;

    logic [NUM_FLOORS-1:0] s_all, s_gt, s_lt, s_cur_oh, s_new_oh, s_req_oh;
    logic s_above, s_below, s_up_mv, s_dn_mv, s_rev, s_opened;
    t_heading s_head;
    logic [FW+FLOOR_OUT_W-1:0] s_floor_ext;

    logic r_out_valid;
    logic [FLOOR_OUT_W-1:0] r_out_floor;
    t_heading r_out_heading;
    logic r_out_moved, r_out_opened, r_out_rejected, r_out_pending;

    assign o_pop = !i_qstat.empty && (!r_out_valid || !i_stall);

    // per-floor masks relative to the car and the request floor
    always_comb begin
        for (int i = 0; i < NUM_FLOORS; i++) begin
            s_gt[i] = (i > int'(r_floor));
            s_lt[i] = (i < int'(r_floor));
            s_cur_oh[i] = (i == int'(r_floor));
            s_req_oh[i] = (i == int'(i_cmd.floor));
        end
    end

    assign s_all = r_up | r_down | r_cab;
    assign s_above = |(s_all & s_gt);
    assign s_below = |(s_all & s_lt);

    // next state
    always_comb begin
        n_up = r_up;
        n_down = r_down;
        n_cab = r_cab;
        n_floor = r_floor;
        n_heading = r_heading;
        s_head = r_heading;
        s_up_mv = 1'b0;
        s_dn_mv = 1'b0;
        s_rev = 1'b0;
        s_opened = 1'b0;
        s_new_oh = s_cur_oh;
        case (i_cmd.action)
            ACT_UP_CALL:   if (!i_cmd.rejected) n_up = r_up | s_req_oh;
            ACT_DOWN_CALL: if (!i_cmd.rejected) n_down = r_down | s_req_oh;
            ACT_CABIN:     if (!i_cmd.rejected) n_cab = r_cab | s_req_oh;
            default: begin
                if (s_all == '0) begin
                    n_heading = HEAD_IDLE;
                end else begin
                    if (s_head == HEAD_IDLE) begin
                        if (s_above) s_head = HEAD_UP;
                        else if (s_below) s_head = HEAD_DOWN;
                    end
                    case (s_head)
                        HEAD_UP: begin
                            if (s_above) s_up_mv = 1'b1;
                            else if (s_below) begin
                                s_head = HEAD_DOWN;
                                s_rev = 1'b1;
                            end
                        end
                        HEAD_DOWN: begin
                            if (s_below) s_dn_mv = 1'b1;
                            else if (s_above) begin
                                s_head = HEAD_UP;
                                s_rev = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    n_heading = s_head;
                    if (s_up_mv) begin
                        n_floor = r_floor + FW'(1);
                        s_new_oh = s_cur_oh << 1;
                    end else if (s_dn_mv) begin
                        n_floor = r_floor - FW'(1);
                        s_new_oh = s_cur_oh >> 1;
                    end
                    if (!s_rev && |(s_all & s_new_oh)) begin
                        n_up = r_up & ~s_new_oh;
                        n_down = r_down & ~s_new_oh;
                        n_cab = r_cab & ~s_new_oh;
                        s_opened = 1'b1;
                    end
                end
            end
        endcase
    end

    assign s_floor_ext = {{FLOOR_OUT_W{1'b0}}, n_floor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= '0;
            r_down <= '0;
            r_cab <= '0;
            r_floor <= '0;
            r_heading <= HEAD_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_up <= n_up;
                r_down <= n_down;
                r_cab <= n_cab;
                r_floor <= n_floor;
                r_heading <= n_heading;
            end
            if (!r_out_valid || !i_stall) r_out_valid <= o_pop;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_floor <= s_floor_ext[FLOOR_OUT_W-1:0];
            r_out_heading <= n_heading;
            r_out_moved <= s_up_mv | s_dn_mv;
            r_out_opened <= s_opened;
            r_out_rejected <= (i_cmd.action != ACT_STEP) && i_cmd.rejected;
            r_out_pending <= |(n_up | n_down | n_cab);
        end
    end

    assign o_valid = r_out_valid;
    assign o_floor_now = r_out_floor;
    assign o_heading = r_out_heading;
    assign o_moved = r_out_moved;
    assign o_doors_opened = r_out_opened;
    assign o_rejected = r_out_rejected;
    assign o_pending = r_out_pending;

    `ASSERT_CLK(a_floor_range, i_clk, i_rst_n, int'(r_floor) < NUM_FLOORS, "car beyond top")
    `ASSERT_NEVER(a_move_idle, i_clk, i_rst_n, r_out_valid && r_out_moved && r_out_heading == HEAD_IDLE, "moved while idle")
    `ASSERT_NEVER(a_rej_action, i_clk, i_rst_n, r_out_valid && r_out_rejected && (r_out_moved || r_out_opened), "rejected word with car action")
    `ASSERT_CLK(a_pop_step, i_clk, i_rst_n, o_pop && (s_up_mv || s_dn_mv) |=> r_floor != $past(r_floor), "move lost")

endmodule

/* rtl/elevator_scan_controller.sv */
// Top level of the single-car elevator scan controller.
// Depends on esc_pkg, esc_front, esc_queue and esc_back.
//
// Input channel (i_valid / o_stall): one word per hall call, cabin request
// or step; a word is taken on a clock edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): exactly one result word per input word,
// in order, held steady while i_stall is high.
// Structure: the front decodes each word and checks its floor against the
// call type, a short queue (QUEUE_DEPTH words) buffers classified words, and
// the back updates per-floor call bits, car floor and heading and loads the
// registered result word on the same edge.
// Path: an accepted word is written into the queue, then the back end pops it
// into the car state and loads the registered result word that drives o_valid.
// Throughput: one word per cycle while o_stall is low; the back end retires one
// queued word in each cycle that the result register is free or being taken.
// Stall: when the receiver stalls, the result register holds, the queue
// fills, and o_stall rises once the queue is full.
// Reset (i_rst_n low, synchronous): all call bits cleared, car at floor 0,
// heading idle, queue and result register empty.
module elevator_scan_controller #(
    parameter int NUM_FLOORS = esc_pkg::DEF_NUM_FLOORS,
    parameter int QUEUE_DEPTH = esc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_action,
    input  logic [esc_pkg::TF_W-1:0]        i_target_floor,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [esc_pkg::FLOOR_OUT_W-1:0] o_floor_now,
    output logic [1:0]                      o_heading,
    output logic                            o_moved,
    output logic                            o_doors_opened,
    output logic                            o_rejected,
    output logic                            o_pending
);
    import esc_pkg::*;

    t_cmd    front_cmd, queue_cmd;
    t_q_stat queue_stat;
    logic    push, pop;

    // stall comes from registered queue fill only
    assign o_stall = queue_stat.full;
    assign push = i_valid && !queue_stat.full;

    esc_front #(
        .NUM_FLOORS(NUM_FLOORS)
    ) u_front (
        .i_action      (i_action),
        .i_target_floor(i_target_floor),
        .o_cmd         (front_cmd)
    );

    esc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .i_pop  (pop),
        .o_cmd  (queue_cmd),
        .o_stat (queue_stat)
    );

    esc_back #(
        .NUM_FLOORS(NUM_FLOORS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_qstat       (queue_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_floor_now   (o_floor_now),
        .o_heading     (o_heading),
        .o_moved       (o_moved),
        .o_doors_opened(o_doors_opened),
        .o_rejected    (o_rejected),
        .o_pending     (o_pending)
    );

endmodule
